/* design/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* design/hepm_pkg.sv */
package hepm_pkg;

  // Field widths
  localparam int SAMPLE_W   = 12;
  localparam int ADC_W      = 13;
  localparam int MV_W       = 16;
  localparam int TIME_W     = 32;
  localparam int LEVEL_W    = 2;
  localparam int PROD_W     = ADC_W + MV_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_LOW      = 3'd0,
    REG_ADC_HIGH     = 3'd1,
    REG_MV_LOW       = 3'd2,
    REG_MV_HIGH      = 3'd3,
    REG_DEAD_LOW     = 3'd4,
    REG_DEAD_HIGH    = 3'd5,
    REG_EDGE_FALLING = 3'd6,
    REG_MAX_INTERVAL = 3'd7
  } reg_index_t;

  // Register reset values
  localparam logic [ADC_W-1:0]  ADC_LOW_RST      = 13'd1876;
  localparam logic [ADC_W-1:0]  ADC_HIGH_RST     = 13'd4096;
  localparam logic [MV_W-1:0]   MV_LOW_RST       = 16'd0;
  localparam logic [MV_W-1:0]   MV_HIGH_RST      = 16'd5000;
  localparam logic [MV_W-1:0]   DEAD_LOW_RST     = 16'd400;
  localparam logic [MV_W-1:0]   DEAD_HIGH_RST    = 16'd4600;
  localparam logic              EDGE_FALLING_RST = 1'b1;
  localparam logic [TIME_W-1:0] MAX_INTERVAL_RST = 32'd2400000;

  // Line level codes
  localparam logic [LEVEL_W-1:0] LEVEL_HIGH = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_LOW  = 2'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_FINISH
  } state_t;

  // Divider control
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

/* design/hepm_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module hepm_div #(
  parameter int NUM_W = hepm_pkg::PROD_W,
  parameter int DEN_W = hepm_pkg::ADC_W
) (
  input  logic                clk,
  input  logic                rst,
  input  hepm_pkg::div_req_t  req,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output hepm_pkg::div_rsp_t  rsp,
  output logic [NUM_W-1:0]    quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dvs;
  logic [NUM_W-1:0] quo;
  logic             done;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   trial;
  logic             fits;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    shifted = {rem, quo[NUM_W-1]};
    trial   = shifted - {1'b0, dvs};
    fits    = (shifted >= {1'b0, dvs});
  end

  // Control: iteration count and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(NUM_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= den;
      quo <= num;
    end else if (cnt != '0) begin
      rem <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign quot     = quo;

endmodule

/* design/hysteresis_edge_period_meter.sv */
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------------
// in       in_valid / in_stall    sample, time_us
// out      out_valid / out_stall  millivolts, line_level, edge_seen,
//                                 interval_valid, interval_us
// cfg      cfg_write              cfg_index, cfg_data
//
// Each sample passes through the states MUL (multiply), DIV (the bit-serial divider
// works out 29 quotient bits and pulses done), SCALE (final offset) and FINISH
// (level and interval compare as the result loads into the output register).
// The next sample is taken only once the result is loaded, never while one is in work.
// in_stall is high during reset and from acceptance until the result is loaded into
// the output register; a stalled output holds the block in its last step.
// Reset (rst, synchronous) restores the register defaults, sets the line high
// and clears the last edge time.
module hysteresis_edge_period_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hepm_pkg::SAMPLE_W-1:0]       sample,
  input  logic [hepm_pkg::TIME_W-1:0]         time_us,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hepm_pkg::MV_W-1:0]           millivolts,
  output logic [hepm_pkg::LEVEL_W-1:0]        line_level,
  output logic                                edge_seen,
  output logic                                interval_valid,
  output logic [hepm_pkg::TIME_W-1:0]         interval_us,
  input  logic                                cfg_write,
  input  logic [hepm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hepm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int ADC_W  = hepm_pkg::ADC_W;
  localparam int MV_W   = hepm_pkg::MV_W;
  localparam int TIME_W = hepm_pkg::TIME_W;
  localparam int PROD_W = hepm_pkg::PROD_W;

  // Configuration registers
  logic [ADC_W-1:0]  adc_low;
  logic [ADC_W-1:0]  adc_high;
  logic [MV_W-1:0]   mv_low;
  logic [MV_W-1:0]   mv_high;
  logic [MV_W-1:0]   dead_low;
  logic [MV_W-1:0]   dead_high;
  logic              edge_falling;
  logic [TIME_W-1:0] max_interval;

  // Sequencer and working registers
  hepm_pkg::state_t   state;
  hepm_pkg::state_t   state_next;
  logic [ADC_W-1:0]   offset;
  logic [TIME_W-1:0]  stamp;
  logic [MV_W-1:0]    mv;
  logic               last_low;
  logic [TIME_W-1:0]  last_edge_time;

  // Datapath nets
  logic [ADC_W-1:0]   code;
  logic [ADC_W-1:0]   clamped;
  logic               neg_scale;
  logic [MV_W-1:0]    span;
  logic [PROD_W-1:0]  product;
  logic [ADC_W-1:0]   window;
  logic [PROD_W-1:0]  quot;
  logic [MV_W-1:0]    mv_scaled;
  logic               in_zone;
  logic               cur_low;
  logic               edge_hit;
  logic               low_next;
  logic [TIME_W-1:0]  elapsed;
  logic               load_out;
  hepm_pkg::div_req_t div_req;
  hepm_pkg::div_rsp_t div_rsp;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      adc_low      <= hepm_pkg::ADC_LOW_RST;
      adc_high     <= hepm_pkg::ADC_HIGH_RST;
      mv_low       <= hepm_pkg::MV_LOW_RST;
      mv_high      <= hepm_pkg::MV_HIGH_RST;
      dead_low     <= hepm_pkg::DEAD_LOW_RST;
      dead_high    <= hepm_pkg::DEAD_HIGH_RST;
      edge_falling <= hepm_pkg::EDGE_FALLING_RST;
      max_interval <= hepm_pkg::MAX_INTERVAL_RST;
    end else if (cfg_write) begin
      unique case (hepm_pkg::reg_index_t'(cfg_index))
        hepm_pkg::REG_ADC_LOW:      adc_low      <= cfg_data[ADC_W-1:0];
        hepm_pkg::REG_ADC_HIGH:     adc_high     <= cfg_data[ADC_W-1:0];
        hepm_pkg::REG_MV_LOW:       mv_low       <= cfg_data[MV_W-1:0];
        hepm_pkg::REG_MV_HIGH:      mv_high      <= cfg_data[MV_W-1:0];
        hepm_pkg::REG_DEAD_LOW:     dead_low     <= cfg_data[MV_W-1:0];
        hepm_pkg::REG_DEAD_HIGH:    dead_high    <= cfg_data[MV_W-1:0];
        hepm_pkg::REG_EDGE_FALLING: edge_falling <= cfg_data[0];
        hepm_pkg::REG_MAX_INTERVAL: max_interval <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the sample into the ADC window
  always_comb begin
    code = {1'b0, sample};
    priority if (code < adc_low) begin
      clamped = adc_low;
    end else if (code > adc_high) begin
      clamped = adc_high;
    end else begin
      clamped = code;
    end
  end

  // Scale magnitude and sign, then the product for the divider
  assign neg_scale = (mv_high < mv_low);
  assign span      = neg_scale ? (mv_low - mv_high) : (mv_high - mv_low);
  assign product   = PROD_W'(offset) * PROD_W'(span);
  assign window    = adc_high - adc_low;
  assign div_req.start = (state == hepm_pkg::ST_MUL);

  hepm_div #(
    .NUM_W (PROD_W),
    .DEN_W (ADC_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (product),
    .den  (window),
    .rsp  (div_rsp),
    .quot (quot)
  );

  // Apply the offset; an empty window gives the low voltage
  always_comb begin
    if (adc_high <= adc_low) begin
      mv_scaled = mv_low;
    end else if (neg_scale) begin
      mv_scaled = mv_low - quot[MV_W-1:0];
    end else begin
      mv_scaled = mv_low + quot[MV_W-1:0];
    end
  end

  // Hysteresis, edge detection and interval
  always_comb begin
    in_zone  = (dead_low <= mv) && (mv <= dead_high);
    cur_low  = (mv < dead_low);
    low_next = in_zone ? last_low : cur_low;
    if (in_zone) begin
      edge_hit = 1'b0;
    end else if (edge_falling) begin
      edge_hit = !last_low && cur_low;
    end else begin
      edge_hit = last_low && !cur_low;
    end
    elapsed  = stamp - last_edge_time;
  end

  assign load_out = (state == hepm_pkg::ST_FINISH) && (!out_valid || !out_stall);

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hepm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and input stall; hold off the input during reset
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      hepm_pkg::ST_IDLE: begin
        in_stall = rst;
        if (in_valid) state_next = hepm_pkg::ST_MUL;
      end
      hepm_pkg::ST_MUL: begin
        state_next = hepm_pkg::ST_DIV;
      end
      hepm_pkg::ST_DIV: begin
        if (div_rsp.done) state_next = hepm_pkg::ST_SCALE;
      end
      hepm_pkg::ST_SCALE: begin
        state_next = hepm_pkg::ST_FINISH;
      end
      hepm_pkg::ST_FINISH: begin
        if (load_out) state_next = hepm_pkg::ST_IDLE;
      end
      default: state_next = hepm_pkg::ST_IDLE;
    endcase
  end

  // Capture the transaction and the scaled voltage
  always_ff @(posedge clk) begin
    if (state == hepm_pkg::ST_IDLE && in_valid) begin
      offset <= clamped - adc_low;
      stamp  <= time_us;
    end
    if (state == hepm_pkg::ST_SCALE) begin
      mv <= mv_scaled;
    end
  end

  // Update line level and edge time as the result leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      last_low       <= 1'b0;
      last_edge_time <= '0;
    end else if (load_out) begin
      last_low <= low_next;
      if (edge_hit) last_edge_time <= stamp;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      millivolts     <= mv;
      line_level     <= low_next ? hepm_pkg::LEVEL_LOW : hepm_pkg::LEVEL_HIGH;
      edge_seen      <= edge_hit;
      interval_valid <= edge_hit && (elapsed < max_interval);
      interval_us    <= edge_hit ? elapsed : '0;
    end
  end

endmodule

/* design/hepm_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the period meter.
module hepm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [hepm_pkg::MV_W-1:0]      millivolts,
  input logic [hepm_pkg::LEVEL_W-1:0]   line_level,
  input logic                           edge_seen,
  input logic                           interval_valid,
  input logic [hepm_pkg::TIME_W-1:0]    interval_us
);

  // Reset empties the output register
  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

  // A taken transaction keeps the input stalled while it is worked on
  `ASSERT_CLK(a_busy_after_accept, clk, rst, (in_valid && !in_stall) |=> in_stall)

  // A reported interval needs an edge, and no edge means a zero interval
  `ASSERT_CLK(a_interval_edge, clk, rst,
    out_valid |-> ((!interval_valid && interval_us == '0) || edge_seen))

  // The line level is only ever high or low
  `ASSERT_CLK(a_level_code, clk, rst,
    out_valid |-> (line_level == hepm_pkg::LEVEL_HIGH || line_level == hepm_pkg::LEVEL_LOW))

  // A stalled result holds
  `ASSERT_CLK(a_out_hold, clk, rst,
    (out_valid && out_stall) |=> (out_valid && $stable(millivolts)))

endmodule

bind hysteresis_edge_period_meter hepm_checker u_hepm_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .millivolts     (millivolts),
  .line_level     (line_level),
  .edge_seen      (edge_seen),
  .interval_valid (interval_valid),
  .interval_us    (interval_us)
);

/* verif/tb_top.sv */
module tb_top;
  import hepm_pkg::*;

  typedef struct {
    logic [SAMPLE_W-1:0] code;
    logic [TIME_W-1:0]   stamp;
  } sample_item_t;

  typedef struct {
    logic [MV_W-1:0]    mv;
    logic [LEVEL_W-1:0] level;
    logic               edge_flag;
    logic               iv_valid;
    logic [TIME_W-1:0]  iv_us;
  } reading_t;

  typedef struct {
    logic [ADC_W-1:0]  adc_lo;
    logic [ADC_W-1:0]  adc_hi;
    logic [MV_W-1:0]   mv_lo;
    logic [MV_W-1:0]   mv_hi;
    logic [MV_W-1:0]   dz_lo;
    logic [MV_W-1:0]   dz_hi;
    logic              falling;
    logic [TIME_W-1:0] max_iv;
  } meter_cfg_t;

  // DUT signals; the inputs are known from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic [TIME_W-1:0]     time_us = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [MV_W-1:0]       millivolts;
  logic [LEVEL_W-1:0]    line_level;
  logic                  edge_seen;
  logic                  interval_valid;
  logic [TIME_W-1:0]     interval_us;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hysteresis_edge_period_meter dut (.*);

  // Pending samples and expected readings
  sample_item_t sample_backlog[$];
  reading_t     pending_readings[$];

  // Predictor copy of the registers and the line state
  meter_cfg_t         cfg_now;
  logic [LEVEL_W-1:0] level_model;
  logic [TIME_W-1:0]  edge_time_model;

  // Stimulus control and tallies
  logic [TIME_W-1:0] clock_us = '0;
  bit  steady_flow = 1'b0;
  bit  in_fire = 1'b0;
  int  squeeze_asked = 0;
  int  squeeze_served = 0;
  int  squeeze_left = 0;
  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  readings_checked = 0;
  int  edges_predicted = 0;
  int  valid_intervals = 0;
  int  settings_loaded = 0;

  always #5 clk = ~clk;

  // Linear map of an ADC code to millivolts, clamped and truncated toward zero
  function automatic logic [MV_W-1:0] scale_code_mv(meter_cfg_t c, logic [SAMPLE_W-1:0] code);
    longint a_lo, a_hi, m_lo, m_hi, x, q;
    a_lo = longint'(c.adc_lo);
    a_hi = longint'(c.adc_hi);
    m_lo = longint'(c.mv_lo);
    m_hi = longint'(c.mv_hi);
    x = longint'(code);
    if (a_hi <= a_lo) return c.mv_lo;
    if (x < a_lo) x = a_lo;
    if (x > a_hi) x = a_hi;
    q = ((x - a_lo) * (m_hi - m_lo)) / (a_hi - a_lo);
    return MV_W'(q + m_lo);
  endfunction

  // Advance the line state by one sample and return the reading it yields
  function automatic reading_t predict_reading(logic [SAMPLE_W-1:0] code,
                                               logic [TIME_W-1:0] stamp);
    reading_t r;
    logic [LEVEL_W-1:0] cur;
    r.mv = scale_code_mv(cfg_now, code);
    r.edge_flag = 1'b0;
    r.iv_valid = 1'b0;
    r.iv_us = '0;
    if (!(cfg_now.dz_lo <= r.mv && r.mv <= cfg_now.dz_hi)) begin
      cur = (r.mv < cfg_now.dz_lo) ? LEVEL_LOW : LEVEL_HIGH;
      if (cfg_now.falling)
        r.edge_flag = (level_model == LEVEL_HIGH) && (cur == LEVEL_LOW);
      else
        r.edge_flag = (level_model == LEVEL_LOW) && (cur == LEVEL_HIGH);
      level_model = cur;
    end
    if (r.edge_flag) begin
      r.iv_us = stamp - edge_time_model;
      edge_time_model = stamp;
      r.iv_valid = (r.iv_us < cfg_now.max_iv);
    end
    r.level = level_model;
    return r;
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // Sample both handshakes; predict on input transactions, check on output ones
  always @(posedge clk) begin
    reading_t want;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      want = predict_reading(sample, time_us);
      pending_readings.push_back(want);
      samples_sent++;
      if (want.edge_flag) edges_predicted++;
      if (want.iv_valid) valid_intervals++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with none expected, actual millivolts %0d", $time,
                 millivolts);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("millivolts", 32'(want.mv), 32'(millivolts));
        check_field("line_level", 32'(want.level), 32'(line_level));
        check_field("edge_seen", 32'(want.edge_flag), 32'(edge_seen));
        check_field("interval_valid", 32'(want.iv_valid), 32'(interval_valid));
        check_field("interval_us", want.iv_us, interval_us);
        readings_checked++;
      end
    end
  end

  // Sender: hold a stalled transaction, otherwise offer the next sample or idle
  always @(negedge clk) begin
    sample_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (sample_backlog.size() != 0 && (steady_flow || $urandom_range(99) >= 21)) begin
      nxt = sample_backlog.pop_front();
      in_valid <= 1'b1;
      sample <= nxt.code;
      time_us <= nxt.stamp;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (squeeze_left > 0) begin
      out_stall <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (squeeze_served != squeeze_asked) begin
      out_stall <= 1'b1;
      squeeze_left <= 400;
      squeeze_served <= squeeze_served + 1;
    end else begin
      out_stall <= steady_flow ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  task automatic write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic load_settings(meter_cfg_t c);
    write_register(REG_ADC_LOW, CFG_DATA_W'(c.adc_lo));
    write_register(REG_ADC_HIGH, CFG_DATA_W'(c.adc_hi));
    write_register(REG_MV_LOW, CFG_DATA_W'(c.mv_lo));
    write_register(REG_MV_HIGH, CFG_DATA_W'(c.mv_hi));
    write_register(REG_DEAD_LOW, CFG_DATA_W'(c.dz_lo));
    write_register(REG_DEAD_HIGH, CFG_DATA_W'(c.dz_hi));
    write_register(REG_EDGE_FALLING, CFG_DATA_W'(c.falling));
    write_register(REG_MAX_INTERVAL, CFG_DATA_W'(c.max_iv));
    cfg_now = c;
    settings_loaded++;
  endtask

  task automatic push_sample(int code, logic [TIME_W-1:0] advance);
    sample_item_t it;
    clock_us = clock_us + advance;
    it.code = SAMPLE_W'(code);
    it.stamp = clock_us;
    sample_backlog.push_back(it);
  endtask

  // Mostly samples aimed below or above the dead zone so the line toggles,
  // the rest uniform noise; timestamps mix short, long and wild jumps
  task automatic queue_random_samples(int n);
    int pick, code, tries;
    logic [MV_W-1:0] mv;
    logic [TIME_W-1:0] advance;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(9);
      code = $urandom_range(4095);
      if (pick < 8) begin
        tries = 0;
        mv = scale_code_mv(cfg_now, SAMPLE_W'(code));
        while (tries < 16 && ((pick < 4) ? !(mv < cfg_now.dz_lo) : !(mv > cfg_now.dz_hi))) begin
          code = $urandom_range(4095);
          mv = scale_code_mv(cfg_now, SAMPLE_W'(code));
          tries++;
        end
      end
      case ($urandom_range(9))
        0: advance = $urandom;
        1, 2, 3, 4, 5: advance = $urandom_range(2000);
        default: advance = $urandom_range(3000000);
      endcase
      push_sample(code, advance);
    end
  endtask

  function automatic meter_cfg_t random_settings();
    meter_cfg_t c;
    int span, base;
    c.adc_lo = ADC_W'($urandom_range(3000));
    if ($urandom_range(7) == 0)
      c.adc_hi = ADC_W'($urandom_range(c.adc_lo));
    else
      c.adc_hi = ADC_W'($urandom_range(4096, c.adc_lo + 1));
    c.mv_lo = MV_W'($urandom_range(65535));
    c.mv_hi = MV_W'($urandom_range(65535));
    base = (c.mv_lo < c.mv_hi) ? int'(c.mv_lo) : int'(c.mv_hi);
    span = (c.mv_lo < c.mv_hi) ? int'(c.mv_hi - c.mv_lo) : int'(c.mv_lo - c.mv_hi);
    c.dz_lo = MV_W'(base + span * $urandom_range(45, 5) / 100);
    c.dz_hi = MV_W'(base + span * $urandom_range(95, 55) / 100);
    if ($urandom_range(5) == 0) {c.dz_lo, c.dz_hi} = {c.dz_hi, c.dz_lo};
    c.falling = 1'($urandom_range(1));
    case ($urandom_range(3))
      0: c.max_iv = $urandom;
      default: c.max_iv = $urandom_range(10000000, 1000);
    endcase
    return c;
  endfunction

  // Wait until every sample is taken and every reading has come back
  task automatic drain_all();
    while (sample_backlog.size() != 0 || in_valid || pending_readings.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    meter_cfg_t c;
    cfg_now = '{ADC_LOW_RST, ADC_HIGH_RST, MV_LOW_RST, MV_HIGH_RST,
                DEAD_LOW_RST, DEAD_HIGH_RST, EDGE_FALLING_RST, MAX_INTERVAL_RST};
    level_model = LEVEL_HIGH;
    edge_time_model = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: clamping, dead zone edge, wrapping timer, interval at the limit
    push_sample(4095, 0);
    push_sample(0, 100);
    push_sample(2054, 100);
    push_sample(4095, 100);
    clock_us = 32'hFFFF_FFF0;
    push_sample(1876, 0);
    push_sample(4095, 5);
    push_sample(0, 27);
    push_sample(4095, 1);
    push_sample(0, 2399999);
    push_sample(4095, 1);
    push_sample(0, 2399998);
    queue_random_samples(120);
    squeeze_asked++;
    drain_all();

    // Identity map, rising edges, exact dead zone bounds
    load_settings('{13'd0, 13'd4096, 16'd0, 16'd4096, 16'd1000, 16'd3000, 1'b0,
                    32'd1000000});
    push_sample(500, 10);
    push_sample(1000, 10);
    push_sample(3000, 10);
    push_sample(3001, 10);
    push_sample(999, 10);
    push_sample(4095, 999989);
    push_sample(0, 10);
    push_sample(4095, 999990);
    queue_random_samples(120);
    drain_all();

    // Falling voltage scale with negative truncating quotients
    load_settings('{13'd100, 13'd4000, 16'd60000, 16'd200, 16'd20000, 16'd40000, 1'b1,
                    32'hFFFF_FFFF});
    push_sample(0, 10);
    push_sample(4095, 10);
    push_sample(2001, 10);
    queue_random_samples(100);
    drain_all();

    // Empty ADC window: every sample maps to the low voltage setting
    load_settings('{13'd4096, 13'd0, 16'd65535, 16'd0, 16'd0, 16'd65534, 1'b0, 32'd0});
    push_sample(0, 10);
    push_sample(4095, 10);
    queue_random_samples(40);
    drain_all();

    // Inverted dead zone: no voltage holds the level
    load_settings('{13'd0, 13'd4096, 16'd0, 16'd4096, 16'd3000, 16'd1000, 1'b1, 32'd5000});
    push_sample(2000, 10);
    push_sample(3000, 10);
    push_sample(500, 10);
    push_sample(4095, 10);
    queue_random_samples(100);
    drain_all();

    // Random settings, extremes first, one phase with no idling at all
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: c = '{13'd0, 13'd4096, 16'd0, 16'd65535, 16'd0, 16'd65535, 1'b1, 32'd0};
        1: c = '{13'd4096, 13'd4096, 16'd65535, 16'd0, 16'd65535, 16'd0, 1'b0,
                 32'hFFFF_FFFF};
        default: c = random_settings();
      endcase
      load_settings(c);
      steady_flow = (p == 3);
      queue_random_samples(130);
      drain_all();
    end
    steady_flow = 1'b0;

    repeat (40) @(posedge clk);
    $display("Covered %0d samples over %0d register settings, %0d readings checked,",
             samples_sent, settings_loaded + 1, readings_checked);
    $display("%0d edges predicted, %0d of them with a reportable interval.",
             edges_predicted, valid_intervals);
    if (mismatch_count == 0 && pending_readings.size() == 0)
      $display("hysteresis_edge_period_meter regression: pass");
    else
      $display("hysteresis_edge_period_meter regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("hysteresis_edge_period_meter regression: fail");
    $finish;
  end

endmodule
